// ----- rtl/mde_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIPS decode/execute package
// Opcode and funct codes, internal operation codes and the stage records that
// travel down the decode/execute pipeline.
// ----------------------------------------------------------------------------
package mde_pkg;

  localparam int XLEN = 32;
  localparam int RLEN = 5;

  // Primary opcodes
  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_J     = 6'h02;
  localparam logic [5:0] OP_JAL   = 6'h03;
  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_BNE   = 6'h05;
  localparam logic [5:0] OP_ADDI  = 6'h08;
  localparam logic [5:0] OP_ADDIU = 6'h09;
  localparam logic [5:0] OP_SLTI  = 6'h0a;
  localparam logic [5:0] OP_SLTIU = 6'h0b;
  localparam logic [5:0] OP_ANDI  = 6'h0c;
  localparam logic [5:0] OP_ORI   = 6'h0d;
  localparam logic [5:0] OP_LUI   = 6'h0f;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_SW    = 6'h2b;

  // R-type funct codes
  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_ADD  = 6'h20;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUB  = 6'h22;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_NOR  = 6'h27;
  localparam logic [5:0] FN_SLT  = 6'h2a;
  localparam logic [5:0] FN_SLTU = 6'h2b;

  localparam logic [RLEN-1:0] LINK_REG  = 5'd31;
  localparam logic [XLEN-1:0] PC_STEP   = 32'd4;
  localparam logic [XLEN-1:0] LINK_STEP = 32'd8;

  typedef enum logic [3:0] {
    ALU_ZERO,
    ALU_ADD,
    ALU_SUB,
    ALU_AND,
    ALU_OR,
    ALU_NOR,
    ALU_SLT,
    ALU_SLTU,
    ALU_SLL,
    ALU_SRL,
    ALU_PASSB
  } alu_op_t;

  typedef enum logic [1:0] {
    BR_NONE,
    BR_EQ,
    BR_NE,
    BR_JUMP
  } br_kind_t;

  // Decode stage record
  typedef struct packed {
    alu_op_t         alu_op;
    logic [XLEN-1:0] opa;
    logic [XLEN-1:0] opb;
    logic [4:0]      shamt;
    logic [RLEN-1:0] dest;
    logic            wr;
    logic            mrd;
    logic            mwr;
    logic            unk;
    br_kind_t        br_kind;
    logic [XLEN-1:0] jtarget;
    logic [XLEN-1:0] pc4;
    logic [XLEN-1:0] br_off;
    logic [XLEN-1:0] sdata;
  } dec_t;

  // Execute stage record
  typedef struct packed {
    logic [XLEN-1:0] res;
    logic [RLEN-1:0] dest;
    logic            wr;
    logic            mrd;
    logic            mwr;
    logic            unk;
    logic            taken;
    logic            is_jump;
    logic [XLEN-1:0] jtarget;
    logic [XLEN-1:0] pc4;
    logic [XLEN-1:0] br_off;
    logic [XLEN-1:0] sdata;
  } exe_t;

endpackage

// ----- rtl/mde_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIPS decode/execute channels
// Instruction channel and result channel, each with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mde_in_if;
  logic               valid;
  logic               ready;
  logic        [31:0] instruction;
  logic        [31:0] instr_pc;
  logic signed [31:0] rs_value;
  logic signed [31:0] rt_value;

  modport source (output valid, instruction, instr_pc, rs_value, rt_value, input ready);
  modport sink   (input valid, instruction, instr_pc, rs_value, rt_value, output ready);
endinterface

interface mde_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] alu_result;
  logic        [4:0]  dest_reg;
  logic               reg_write;
  logic               mem_read;
  logic               mem_write;
  logic        [31:0] mem_address;
  logic signed [31:0] store_data;
  logic               redirect;
  logic        [31:0] next_pc;
  logic               unknown_op;

  modport source (output valid, alu_result, dest_reg, reg_write, mem_read, mem_write,
                  mem_address, store_data, redirect, next_pc, unknown_op, input ready);
  modport sink   (input valid, alu_result, dest_reg, reg_write, mem_read, mem_write,
                  mem_address, store_data, redirect, next_pc, unknown_op, output ready);
endinterface

// ----- rtl/mde_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIPS decode stage
// Splits the instruction word, extends the immediate, selects the ALU
// operands and the control bits, and registers the decoded record.
// ----------------------------------------------------------------------------
module mde_decode (
  input  logic          clk,
  input  logic          rst,
  mde_in_if.sink        instr,
  output logic          valid,
  output mde_pkg::dec_t dec,
  input  logic          ready_dn
);
  import mde_pkg::*;

  logic [5:0]      op;
  logic [5:0]      funct;
  logic [4:0]      rt;
  logic [4:0]      rd;
  logic [15:0]     imm;
  logic [XLEN-1:0] simm;
  logic [XLEN-1:0] zimm;
  logic [XLEN-1:0] pc4;
  dec_t            dec_next;

  assign op    = instr.instruction[31:26];
  assign rt    = instr.instruction[20:16];
  assign rd    = instr.instruction[15:11];
  assign funct = instr.instruction[5:0];
  assign imm   = instr.instruction[15:0];
  assign simm  = {{16{imm[15]}}, imm};
  assign zimm  = {16'h0000, imm};
  assign pc4   = instr.instr_pc + PC_STEP;

  always_comb begin
    dec_next         = '0;
    dec_next.alu_op  = ALU_ZERO;
    dec_next.br_kind = BR_NONE;
    dec_next.opa     = instr.rs_value;
    dec_next.opb     = instr.rt_value;
    dec_next.shamt   = instr.instruction[10:6];
    dec_next.pc4     = pc4;
    dec_next.br_off  = {simm[XLEN-3:0], 2'b00};
    dec_next.jtarget = {pc4[31:28], instr.instruction[25:0], 2'b00};
    if (op == OP_RTYPE) begin
      dec_next.dest = rd;
      dec_next.wr   = 1'b1;
      unique case (funct)
        FN_ADD, FN_ADDU: dec_next.alu_op = ALU_ADD;
        FN_SUB, FN_SUBU: dec_next.alu_op = ALU_SUB;
        FN_AND:          dec_next.alu_op = ALU_AND;
        FN_OR:           dec_next.alu_op = ALU_OR;
        FN_NOR:          dec_next.alu_op = ALU_NOR;
        FN_SLT:          dec_next.alu_op = ALU_SLT;
        FN_SLTU:         dec_next.alu_op = ALU_SLTU;
        FN_SLL:          dec_next.alu_op = ALU_SLL;
        FN_SRL:          dec_next.alu_op = ALU_SRL;
        FN_JR: begin
          dec_next.dest    = '0;
          dec_next.wr      = 1'b0;
          dec_next.br_kind = BR_JUMP;
          dec_next.jtarget = instr.rs_value;
        end
        default: begin
          dec_next.dest = '0;
          dec_next.wr   = 1'b0;
          dec_next.unk  = 1'b1;
        end
      endcase
    end else begin
      dec_next.dest = rt;
      dec_next.wr   = 1'b1;
      unique case (op)
        OP_ADDI, OP_ADDIU: begin
          dec_next.alu_op = ALU_ADD;
          dec_next.opb    = simm;
        end
        OP_SLTI: begin
          dec_next.alu_op = ALU_SLT;
          dec_next.opb    = simm;
        end
        OP_SLTIU: begin
          dec_next.alu_op = ALU_SLTU;
          dec_next.opb    = simm;
        end
        OP_ANDI: begin
          dec_next.alu_op = ALU_AND;
          dec_next.opb    = zimm;
        end
        OP_ORI: begin
          dec_next.alu_op = ALU_OR;
          dec_next.opb    = zimm;
        end
        OP_LUI: begin
          dec_next.alu_op = ALU_PASSB;
          dec_next.opb    = {imm, 16'h0000};
        end
        OP_LW: begin
          dec_next.alu_op = ALU_ADD;
          dec_next.opb    = simm;
          dec_next.mrd    = 1'b1;
        end
        OP_SW: begin
          dec_next.alu_op = ALU_ADD;
          dec_next.opb    = simm;
          dec_next.mwr    = 1'b1;
          dec_next.sdata  = instr.rt_value;
          dec_next.dest   = '0;
          dec_next.wr     = 1'b0;
        end
        OP_BEQ, OP_BNE: begin
          dec_next.dest    = '0;
          dec_next.wr      = 1'b0;
          dec_next.br_kind = (op == OP_BEQ) ? BR_EQ : BR_NE;
        end
        OP_J: begin
          dec_next.dest    = '0;
          dec_next.wr      = 1'b0;
          dec_next.br_kind = BR_JUMP;
        end
        OP_JAL: begin
          // The link value pc+8 is formed by the ALU adder.
          dec_next.dest    = LINK_REG;
          dec_next.alu_op  = ALU_ADD;
          dec_next.opa     = instr.instr_pc;
          dec_next.opb     = LINK_STEP;
          dec_next.br_kind = BR_JUMP;
        end
        default: begin
          dec_next.dest = '0;
          dec_next.wr   = 1'b0;
          dec_next.unk  = 1'b1;
        end
      endcase
    end
    if (dec_next.dest == '0) begin
      dec_next.wr = 1'b0;
    end
  end

  // No instruction beat is taken while reset is held.
  assign instr.ready = !rst && (!valid || ready_dn);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (instr.ready) begin
      valid <= instr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (instr.ready && instr.valid) begin
      dec <= dec_next;
    end
  end

endmodule

// ----- rtl/mde_execute.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIPS execute stage
// Runs the ALU on the decoded operands and resolves the branch condition.
// ----------------------------------------------------------------------------
module mde_execute (
  input  logic          clk,
  input  logic          rst,
  input  logic          valid_up,
  input  mde_pkg::dec_t dec,
  output logic          ready_up,
  output logic          valid,
  output mde_pkg::exe_t exe,
  input  logic          ready_dn
);
  import mde_pkg::*;

  logic [XLEN-1:0] res;
  logic            eq;
  logic            taken;
  exe_t            exe_next;

  always_comb begin
    unique case (dec.alu_op)
      ALU_ADD:   res = dec.opa + dec.opb;
      ALU_SUB:   res = dec.opa - dec.opb;
      ALU_AND:   res = dec.opa & dec.opb;
      ALU_OR:    res = dec.opa | dec.opb;
      ALU_NOR:   res = ~(dec.opa | dec.opb);
      ALU_SLT:   res = {{(XLEN-1){1'b0}}, ($signed(dec.opa) < $signed(dec.opb))};
      ALU_SLTU:  res = {{(XLEN-1){1'b0}}, (dec.opa < dec.opb)};
      ALU_SLL:   res = dec.opb << dec.shamt;
      ALU_SRL:   res = dec.opb >> dec.shamt;
      ALU_PASSB: res = dec.opb;
      default:   res = '0;
    endcase
  end

  assign eq = (dec.opa == dec.opb);

  always_comb begin
    unique case (dec.br_kind)
      BR_EQ:   taken = eq;
      BR_NE:   taken = !eq;
      BR_JUMP: taken = 1'b1;
      default: taken = 1'b0;
    endcase
  end

  always_comb begin
    exe_next.res     = res;
    exe_next.dest    = dec.dest;
    exe_next.wr      = dec.wr;
    exe_next.mrd     = dec.mrd;
    exe_next.mwr     = dec.mwr;
    exe_next.unk     = dec.unk;
    exe_next.taken   = taken;
    exe_next.is_jump = (dec.br_kind == BR_JUMP);
    exe_next.jtarget = dec.jtarget;
    exe_next.pc4     = dec.pc4;
    exe_next.br_off  = dec.br_off;
    exe_next.sdata   = dec.sdata;
  end

  assign ready_up = !valid || ready_dn;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready_up) begin
      valid <= valid_up;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up && valid_up) begin
      exe <= exe_next;
    end
  end

endmodule

// ----- rtl/mde_retire.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIPS result stage
// Forms the branch target and next pc, masks the memory address and holds the
// result beat in the output register until it is taken.
// ----------------------------------------------------------------------------
module mde_retire (
  input  logic          clk,
  input  logic          rst,
  input  logic          valid_up,
  input  mde_pkg::exe_t exe,
  output logic          ready_up,
  mde_out_if.source     result
);
  import mde_pkg::*;

  logic [XLEN-1:0] npc_next;
  logic            mem_op;

  always_comb begin
    priority if (!exe.taken) begin
      npc_next = exe.pc4;
    end else if (exe.is_jump) begin
      npc_next = exe.jtarget;
    end else begin
      npc_next = exe.pc4 + exe.br_off;
    end
  end

  assign mem_op   = exe.mrd || exe.mwr;
  assign ready_up = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (ready_up) begin
      result.valid <= valid_up;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up && valid_up) begin
      result.alu_result  <= exe.res;
      result.dest_reg    <= exe.dest;
      result.reg_write   <= exe.wr;
      result.mem_read    <= exe.mrd;
      result.mem_write   <= exe.mwr;
      result.mem_address <= mem_op ? exe.res : '0;
      result.store_data  <= exe.sdata;
      result.redirect    <= exe.taken;
      result.next_pc     <= npc_next;
      result.unknown_op  <= exe.unk;
    end
  end

endmodule

// ----- rtl/mips_decode_execute_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIPS decode/execute unit
// Three-stage pipeline: decode, ALU execute, next-pc and result register.
// ----------------------------------------------------------------------------
// Each accepted instruction beat passes the decode, execute and result registers.
// Throughput: one instruction per cycle while result.ready is high; each stage
// holds one beat and moves as soon as the stage after it is empty or advancing.
// Reset: synchronous, clears the stage valid bits; payloads are not reset.
module mips_decode_execute_unit (
  input logic       clk,
  input logic       rst,
  mde_in_if.sink    instr,
  mde_out_if.source result
);
  import mde_pkg::*;

  logic dec_valid;
  logic exe_valid;
  logic exe_ready;
  logic ret_ready;
  dec_t dec;
  exe_t exe;

  mde_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .instr    (instr),
    .valid    (dec_valid),
    .dec      (dec),
    .ready_dn (exe_ready)
  );

  mde_execute u_execute (
    .clk      (clk),
    .rst      (rst),
    .valid_up (dec_valid),
    .dec      (dec),
    .ready_up (exe_ready),
    .valid    (exe_valid),
    .exe      (exe),
    .ready_dn (ret_ready)
  );

  mde_retire u_retire (
    .clk      (clk),
    .rst      (rst),
    .valid_up (exe_valid),
    .exe      (exe),
    .ready_up (ret_ready),
    .result   (result)
  );

endmodule

// ----- rtl/mde_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIPS decode/execute port checker
// Watches the result channel for consistent control bits and held beats.
// ----------------------------------------------------------------------------
module mde_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [4:0]  dest_reg,
  input logic        reg_write,
  input logic        mem_read,
  input logic        mem_write,
  input logic        redirect,
  input logic [31:0] next_pc,
  input logic        unknown_op
);

  // A stalled result beat must hold its next pc.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(next_pc))
    else $error("stalled result beat changed");

  a_r0: assert property (@(posedge clk) disable iff (rst)
    out_valid && reg_write |-> dest_reg != 5'd0)
    else $error("write to register zero");

  // An unknown code must not touch registers, memory or the pc.
  a_unk: assert property (@(posedge clk) disable iff (rst)
    out_valid && unknown_op |-> !reg_write && !mem_read && !mem_write && !redirect)
    else $error("unknown code had side effects");

  a_store: assert property (@(posedge clk) disable iff (rst)
    out_valid && mem_write |-> !mem_read && !reg_write && !redirect)
    else $error("store beat with other controls");

endmodule

bind mips_decode_execute_unit mde_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .dest_reg   (result.dest_reg),
  .reg_write  (result.reg_write),
  .mem_read   (result.mem_read),
  .mem_write  (result.mem_write),
  .redirect   (result.redirect),
  .next_pc    (result.next_pc),
  .unknown_op (result.unknown_op)
);
